// ===== rtl/sorted_date_key_set_top_assert.svh =====
// assertion macros for the sorted date key set
// used by sorted_date_key_set_top; no other dependencies
`ifndef SORTED_DATE_KEY_SET_TOP_ASSERT_SVH
`define SORTED_DATE_KEY_SET_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle
`define SDKS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted date key set: same-cycle check failed");

// condition holds in the next cycle
`define SDKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted date key set: next-cycle check failed");

`else

`define SDKS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SDKS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/sdks_pkg.sv =====
// shared types and codes for the sorted date key set
// no dependencies
package sdks_pkg;

  localparam int DEF_CAPACITY = 64;

  // opcodes
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [5:0]  index;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [6:0]  entry_count;
    logic [31:0] entry_value;
    logic [1:0]  status;
  } out_word_t;

endpackage

// ===== rtl/sorted_date_key_set_top.sv =====
// sorted date key set: sequencer, count and result register around the key store
// depends on sdks_pkg, sdks_key_ram and sorted_date_key_set_top_assert.svh
//
//   channel   direction  handshake            word
//   in        input      in_valid / in_stall  sdks_pkg::in_word_t
//   out       output     out_valid / out_stall sdks_pkg::out_word_t
//
// one item at a time; add, remove and lookup binary search, each probe passing
// S_SEARCH and S_CMP; add then shifts count-pos entries up one per cycle and
// writes the key in S_INSERT; remove shifts count-pos-1 down. read in range
// passes S_READ_WAIT; clear, unused opcodes and read out of range go to S_DONE.
// rst clears count and control and holds in_stall; the store needs no clearing.
// a result held under out_stall keeps the next one in its last cycle.
`include "sorted_date_key_set_top_assert.svh"

module sorted_date_key_set_top #(
  parameter int CAPACITY = sdks_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sdks_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output sdks_pkg::out_word_t out_word
);

  import sdks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_SEARCH     = 9'b000000010,
    S_CMP        = 9'b000000100,
    S_DECIDE     = 9'b000001000,
    S_SHIFT_UP   = 9'b000010000,
    S_SHIFT_DOWN = 9'b000100000,
    S_INSERT     = 9'b001000000,
    S_READ_WAIT  = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic          eq;
  logic [AW-1:0] mid;
  logic [AW-1:0] ptr;
  logic [2:0]    op;
  logic [31:0]   key;
  logic          res_hit;
  logic [31:0]   res_value;
  logic [1:0]    res_status;

  logic          accept;
  logic          idx_ok;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_c;
  logic [CW-1:0] count_m1;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  sdks_key_ram #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and helpers
  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = (32'(in_word.index) < 32'(count));
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_c    = AW'(mid_sum[CW:1]);
  assign count_m1 = count - CW'(1);

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    ram_raddr = mid_c;
    unique case (state) inside
      S_IDLE: begin
        ram_raddr = AW'(in_word.index);
      end
      S_SEARCH: begin
        ram_raddr = mid_c;
      end
      S_DECIDE: begin
        if (op == OP_ADD) begin
          ram_raddr = AW'(count_m1);
        end else begin
          ram_raddr = AW'(lo + CW'(1));
        end
      end
      S_SHIFT_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr + AW'(1);
        ram_raddr = ptr - AW'(1);
      end
      S_SHIFT_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr - AW'(1);
        ram_raddr = ptr + AW'(1);
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(lo);
        ram_wdata = key;
      end
      S_CMP, S_READ_WAIT, S_DONE: begin
        ram_raddr = mid_c;
      end
      default: begin
        ram_raddr = mid_c;
      end
    endcase
  end

  // operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= in_word.opcode;
            key        <= in_word.key;
            res_hit    <= 1'b0;
            res_value  <= '0;
            res_status <= ST_OK;
            lo         <= '0;
            hi         <= count;
            eq         <= 1'b0;
            case (in_word.opcode) inside
              OP_ADD, OP_REMOVE, OP_LOOKUP: begin
                state <= S_SEARCH;
              end
              OP_CLEAR: begin
                count <= '0;
                state <= S_DONE;
              end
              OP_READ: begin
                if (idx_ok) begin
                  state <= S_READ_WAIT;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_c;
            state <= S_CMP;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_CMP: begin
          // lower bound step; eq follows the latest probe that moved hi
          if (ram_rdata < key) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
            eq <= (ram_rdata == key);
          end
          state <= S_SEARCH;
        end
        S_DECIDE: begin
          res_hit <= eq;
          case (op)
            OP_ADD: begin
              if (eq) begin
                state <= S_DONE;
              end else if (count == CAP_C) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (lo == count) begin
                state <= S_INSERT;
              end else begin
                ptr   <= AW'(count_m1);
                state <= S_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (!eq) begin
                state <= S_DONE;
              end else if (lo == count_m1) begin
                count <= count_m1;
                state <= S_DONE;
              end else begin
                ptr   <= AW'(lo + CW'(1));
                state <= S_SHIFT_DOWN;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SHIFT_UP: begin
          // open a gap at the insert position
          if (ptr == AW'(lo)) begin
            state <= S_INSERT;
          end else begin
            ptr <= ptr - AW'(1);
          end
        end
        S_SHIFT_DOWN: begin
          // close the gap left by the removed key
          if (CW'(ptr) == count_m1) begin
            count <= count_m1;
            state <= S_DONE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_INSERT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_READ_WAIT: begin
          res_value <= ram_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_word.hit         <= res_hit;
      out_word.entry_count <= 7'(count);
      out_word.entry_value <= res_value;
      out_word.status      <= res_status;
    end
  end

  // checks
  `SDKS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CAP_C)
  `SDKS_ASSERT_SAME(a_shift_up_room, clk, rst, state == S_SHIFT_UP, count < CAP_C)
  `SDKS_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, state != S_IDLE)
  `SDKS_ASSERT_NEXT(a_clear_empties, clk, rst, accept && in_word.opcode == OP_CLEAR, count == '0)

endmodule

// ===== rtl/sdks_key_ram.sv =====
// key store: one write port, one read port with registered read data
// no package dependencies
module sdks_key_ram #(
  parameter int CAPACITY = 64,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb_sorted_date_key_set_top.sv =====
// self-checking testbench for sorted_date_key_set_top: directed table, then random op segments
// depends on sdks_pkg and sorted_date_key_set_top; keeps its own sorted-set model for expected words
module tb_sorted_date_key_set_top;
  import sdks_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [2:0] OP_SPARE_LO = OP_READ + 3'd1;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // random segment flavors
  typedef enum int {SEG_FILL, SEG_MIXED, SEG_DRAIN} seg_kind_t;

  // one directed row: the word sent and, where typed, the result it must give
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } plan_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // model of the set, updated as words are accepted
  logic [31:0] set_keys [CAPACITY];
  int          set_count;

  out_word_t   pending_results [$];
  plan_row_t   plan [$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  sorted_date_key_set_top #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sorted_date_key_set_top");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // apply one op to the set model and return the word it gives
  function automatic out_word_t apply_set_op(input in_word_t w);
    out_word_t r;
    int        pos;
    int        i;
    bit        present;
    r = '0;
    pos = 0;
    while (pos < set_count && set_keys[pos] < w.key) pos++;
    present = (pos < set_count) && (set_keys[pos] == w.key);
    case (w.opcode)
      OP_ADD: begin
        if (present) begin
          r.hit = 1'b1;
        end else if (set_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = set_count; i > pos; i--) set_keys[i] = set_keys[i - 1];
          set_keys[pos] = w.key;
          set_count++;
        end
      end
      OP_REMOVE: begin
        if (present) begin
          r.hit = 1'b1;
          for (i = pos; i < set_count - 1; i++) set_keys[i] = set_keys[i + 1];
          set_count--;
        end
      end
      OP_LOOKUP: r.hit = present;
      OP_CLEAR: set_count = 0;
      OP_READ: begin
        if (int'(w.index) < set_count) begin
          r.entry_value = set_keys[w.index];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(set_count);
    return r;
  endfunction

  function automatic logic [31:0] make_date(input int y, input int m, input int d);
    return 32'(y * 10000 + m * 100 + d);
  endfunction

  // key: a stored one with some chance, else a date, full random or an extreme
  function automatic logic [31:0] pick_key(input int stored_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < stored_pct && set_count > 0) return set_keys[$urandom_range(0, set_count - 1)];
    r = $urandom_range(0, 9);
    if (r < 7)
      return make_date($urandom_range(1900, 2099), $urandom_range(1, 12), $urandom_range(1, 31));
    if (r < 9) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic in_word_t random_word(input seg_kind_t kind);
    in_word_t w;
    int       r;
    int       add_w;
    int       rem_w;
    int       look_w;
    int       read_w;
    int       clr_w;
    case (kind)
      SEG_FILL:  begin add_w = 85; rem_w = 3;  look_w = 5;  read_w = 5;  clr_w = 0; end
      SEG_MIXED: begin add_w = 30; rem_w = 25; look_w = 20; read_w = 21; clr_w = 1; end
      default:   begin add_w = 10; rem_w = 55; look_w = 15; read_w = 16; clr_w = 2; end
    endcase
    r = $urandom_range(0, 99);
    if (r < add_w) w.opcode = OP_ADD;
    else if (r < add_w + rem_w) w.opcode = OP_REMOVE;
    else if (r < add_w + rem_w + look_w) w.opcode = OP_LOOKUP;
    else if (r < add_w + rem_w + look_w + read_w) w.opcode = OP_READ;
    else if (r < add_w + rem_w + look_w + read_w + clr_w) w.opcode = OP_CLEAR;
    else w.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    w.key = pick_key(w.opcode == OP_ADD ? 30 : 70);
    if (set_count > 0 && $urandom_range(0, 1) == 1)
      w.index = 6'($urandom_range(0, set_count - 1));
    else
      w.index = 6'($urandom_range(0, 63));
    return w;
  endfunction

  // drive one word, wait for it to be taken, queue its expected result
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_result);
    out_word_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_set_op(w);
    pending_results = {pending_results, (typed ? typed_result : predicted)};
    @(negedge clk);
  endtask

  task automatic add_row(input logic [2:0] op, input logic [31:0] key, input logic [5:0] idx,
                         input bit typed, input logic hit, input logic [6:0] cnt,
                         input logic [31:0] value, input logic [1:0] st);
    plan_row_t row;
    row.word.opcode = op;
    row.word.key = key;
    row.word.index = idx;
    row.typed = typed;
    row.result.hit = hit;
    row.result.entry_count = cnt;
    row.result.entry_value = value;
    row.result.status = st;
    plan = {plan, row};
  endtask

  // receiver stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_word));
      end else begin
        want = pending_results.pop_front();
        if (out_word.hit !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", out_word.hit, want.hit));
        if (out_word.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_word.entry_count, want.entry_count));
        if (out_word.entry_value !== want.entry_value)
          report_mismatch($sformatf("entry_value got %h want %h",
                                    out_word.entry_value, want.entry_value));
        if (out_word.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_word.status, want.status));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    seg_kind_t kind;
    int        seg_len;
    int        sent;
    int        j;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    error_count = 0;
    cycle_count = 0;
    set_count = 0;
    send_idle_pct = 27;
    recv_stall_pct = 52;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: empty store, extremes, duplicates, reads in and out of range
    add_row(OP_READ,   32'd0,        6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_RANGE);
    add_row(OP_LOOKUP, 32'd0,        6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_REMOVE, 32'd20240101, 6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_ADD,    32'd20240101, 6'd0,  1'b1, 1'b0, 7'd1, 32'd0,        ST_OK);
    add_row(OP_ADD,    32'd20240101, 6'd0,  1'b1, 1'b1, 7'd1, 32'd0,        ST_OK);
    add_row(OP_ADD,    32'h0000_0000, 6'd0, 1'b1, 1'b0, 7'd2, 32'd0,        ST_OK);
    add_row(OP_ADD,    32'hFFFF_FFFF, 6'd0, 1'b1, 1'b0, 7'd3, 32'd0,        ST_OK);
    add_row(OP_READ,   32'd0,        6'd0,  1'b1, 1'b0, 7'd3, 32'd0,        ST_OK);
    add_row(OP_READ,   32'd0,        6'd2,  1'b1, 1'b0, 7'd3, 32'hFFFF_FFFF, ST_OK);
    add_row(OP_READ,   32'd0,        6'd1,  1'b1, 1'b0, 7'd3, 32'd20240101, ST_OK);
    add_row(OP_READ,   32'd0,        6'd3,  1'b1, 1'b0, 7'd3, 32'd0,        ST_RANGE);
    add_row(OP_READ,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 7'd3, 32'd0,       ST_RANGE);
    add_row(OP_ADD,    32'd19991231, 6'd63, 1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_LOOKUP, 32'd19991231, 6'd0,  1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_LOOKUP, 32'd20991231, 6'd0,  1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_REMOVE, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_REMOVE, 32'h0000_0000, 6'd0, 1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    // unused opcodes leave the set alone
    add_row(OP_SPARE_LO, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 7'd0, 32'd0,     ST_OK);
    add_row(OP_SPARE_HI, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 7'd0, 32'd0,     ST_OK);
    add_row(OP_SPARE_LO + 3'd1, 32'd20240101, 6'd1, 1'b0, 1'b0, 7'd0, 32'd0, ST_OK);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_CLEAR,  32'd0,        6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_READ,   32'd0,        6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_RANGE);
    add_row(OP_LOOKUP, 32'd20240101, 6'd0,  1'b1, 1'b0, 7'd0, 32'd0,        ST_OK);
    add_row(OP_ADD,    32'h8000_0000, 6'd0, 1'b1, 1'b0, 7'd1, 32'd0,        ST_OK);

    @(negedge clk);
    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].result);

    // random segments; the first one fills the store so that full adds occur
    sent = 0;
    kind = SEG_FILL;
    seg_len = 120;
    while (sent < RANDOM_ITEMS) begin
      for (j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
        if (sent < RANDOM_ITEMS / 3) begin
          send_idle_pct = 27;
          recv_stall_pct = 52;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 52;
          recv_stall_pct = 27;
        end else begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        send_word(random_word(kind), 1'b0, '0);
        sent++;
      end
      kind = seg_kind_t'($urandom_range(SEG_FILL, SEG_DRAIN));
      seg_len = $urandom_range(30, 100);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS sorted_date_key_set_top");
    end else begin
      $display("FAIL sorted_date_key_set_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sdks_pkg.sv
rtl/sdks_key_ram.sv
rtl/sorted_date_key_set_top.sv
tb/tb_sorted_date_key_set_top.sv
